### rtl/fully_assoc_lru_writeback_tags_macros.svh
// Assertion macros for the fully associative LRU write-back tag controller.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef FULLY_ASSOC_LRU_WRITEBACK_TAGS_MACROS_SVH
`define FULLY_ASSOC_LRU_WRITEBACK_TAGS_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FALWBT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define FALWBT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FALWBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/falwbt_pkg.sv
// Shared constants and types of the fully associative LRU write-back tag controller.
// Used by falwbt_way and fully_assoc_lru_writeback_tags; depends on nothing.
package falwbt_pkg;

   localparam int NUM_WAYS      = 64;
   localparam int WAY_BITS      = $clog2(NUM_WAYS);
   localparam int TAG_BITS      = 40;
   localparam int ADDR_BITS     = 40;
   localparam int GRAN_BITS     = 13;
   localparam int WB_BITS       = 52;
   localparam int USED_WAY_BITS = 6;
   localparam int PROD_BITS     = TAG_BITS + GRAN_BITS;

   localparam logic [GRAN_BITS-1:0] GRAN_RESET  = GRAN_BITS'(64);
   localparam logic [WAY_BITS-1:0]  OLDEST_RANK = WAY_BITS'(NUM_WAYS - 1);

   // Update broadcast from the lookup stage to every way.
   typedef struct packed {
      logic                upd;
      logic                hit_any;
      logic                is_store;
      logic [WAY_BITS-1:0] used_rank;
   } falwbt_ctl_type;

   // Per-way status toward the lookup stage.
   typedef struct packed {
      logic                match;
      logic                oldest;
      logic                valid;
      logic                dirty;
      logic [WAY_BITS-1:0] rank;
   } falwbt_sts_type;

endpackage

### rtl/falwbt_way.sv
// One cache way: tag, valid, dirty and recency rank (0 = most recently used).
// Depends on falwbt_pkg.
module falwbt_way (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [falwbt_pkg::WAY_BITS-1:0]   way_index,
   input  logic [falwbt_pkg::TAG_BITS-1:0]   lookup_tag,
   input  falwbt_pkg::falwbt_ctl_type        ctl,
   output falwbt_pkg::falwbt_sts_type        sts,
   output logic [falwbt_pkg::TAG_BITS-1:0]   tag
);

   logic [falwbt_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic                            valid_ff, valid_in;
   logic                            dirty_ff, dirty_in;
   logic [falwbt_pkg::WAY_BITS-1:0] rank_ff, rank_in;
   logic                            sel;

   assign sts.match  = valid_ff && (tag_ff == lookup_tag);
   assign sts.oldest = (rank_ff == falwbt_pkg::OLDEST_RANK);
   assign sts.valid  = valid_ff;
   assign sts.dirty  = dirty_ff;
   assign sts.rank   = rank_ff;
   assign tag        = tag_ff;

   assign sel = ctl.hit_any ? sts.match : sts.oldest;

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      if (ctl.upd) begin
         if (sel) begin
            rank_in = '0;
            if (ctl.hit_any) begin
               if (ctl.is_store) begin
                  dirty_in = 1'b1;
               end
            end else begin
               tag_in   = lookup_tag;
               valid_in = 1'b1;
               dirty_in = ctl.is_store;
            end
         end else if (rank_ff < ctl.used_rank) begin
            // age the ways that were newer than the one moved to the front
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= way_index;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

### rtl/fully_assoc_lru_writeback_tags.sv
// Top level of the fully associative write-back, write-allocate tag controller.
// Depends on falwbt_pkg, falwbt_way and fully_assoc_lru_writeback_tags_macros.svh.

// Tag and exact-LRU replacement controller for a 64-way fully associative
// write-back cache. Each request transaction (load or store to a line address)
// yields exactly one response transaction: hit, fetch request for a load miss,
// dirty or clean eviction flags, the writeback address (victim tag times the
// granularity register) and the way used. One transaction is taken per cycle
// while nothing stalls. The stages are: request register, lookup (parallel
// tag compare over all ways plus the recency-rank update, which is where state
// changes), and the writeback-address multiplier feeding the response register.
// Recency is kept as one rank per way; after reset way i has rank i, so way 0
// is newest and the last way is the first victim. The granularity register
// resets to 64 and is written through csr_we/csr_wdata; the user must write it
// only while no transaction is in flight, which the block does not enforce.
`include "fully_assoc_lru_writeback_tags_macros.svh"

module fully_assoc_lru_writeback_tags (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [falwbt_pkg::ADDR_BITS-1:0]       req_line_addr,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic                                   rsp_fetch_line,
   output logic                                   rsp_dirty_evict,
   output logic                                   rsp_clean_evict,
   output logic [falwbt_pkg::WB_BITS-1:0]         rsp_writeback_address,
   output logic [falwbt_pkg::USED_WAY_BITS-1:0]   rsp_used_way,
   // granularity register
   input  logic                                   csr_we,
   input  logic [falwbt_pkg::GRAN_BITS-1:0]       csr_wdata
);

   localparam int NW = falwbt_pkg::NUM_WAYS;
   localparam int WB = falwbt_pkg::WAY_BITS;
   localparam int TB = falwbt_pkg::TAG_BITS;

   // Granularity register.
   logic [falwbt_pkg::GRAN_BITS-1:0] gran_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff <= falwbt_pkg::GRAN_RESET;
      end else if (csr_we) begin
         gran_ff <= csr_wdata;
      end
   end

   // Flow control: each stage advances when the one after it is empty or moving.
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic s0_free, s1_free, s2_free, s0_move;

   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign s0_move   = s0_valid_ff && s1_free;
   assign req_stall = !s0_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_free) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage 0: request register.
   logic          s0_store_ff;
   logic [TB-1:0] s0_tag_ff;

   always_ff @(posedge clock) begin
      if (s0_free) begin
         s0_store_ff <= req_func;
         s0_tag_ff   <= TB'(req_line_addr);
      end
   end

   // Way array.
   falwbt_pkg::falwbt_ctl_type ctl;
   falwbt_pkg::falwbt_sts_type way_sts [NW];
   logic [TB-1:0]              way_tag [NW];

   for (genvar g = 0; g < NW; g++) begin : g_way
      falwbt_way u_way (
         .clock      (clock),
         .reset      (reset),
         .way_index  (WB'(g)),
         .lookup_tag (s0_tag_ff),
         .ctl        (ctl),
         .sts        (way_sts[g]),
         .tag        (way_tag[g])
      );
   end

   // Lookup: fold the per-way status into hit and victim information.
   // At most one way matches and exactly one way is oldest, so OR-folding selects.
   logic [NW-1:0] match_vec, oldest_vec;
   logic          hit_any;
   logic [WB-1:0] hit_way, hit_rank, evict_way, used_way;
   logic [TB-1:0] victim_tag;
   logic          victim_valid, victim_dirty;

   always_comb begin
      hit_way      = '0;
      hit_rank     = '0;
      evict_way    = '0;
      victim_tag   = '0;
      victim_valid = 1'b0;
      victim_dirty = 1'b0;
      for (int i = 0; i < NW; i++) begin
         match_vec[i]  = way_sts[i].match;
         oldest_vec[i] = way_sts[i].oldest;
         if (way_sts[i].match) begin
            hit_way  = hit_way | WB'(i);
            hit_rank = hit_rank | way_sts[i].rank;
         end
         if (way_sts[i].oldest) begin
            evict_way    = evict_way | WB'(i);
            victim_tag   = victim_tag | way_tag[i];
            victim_valid = victim_valid | way_sts[i].valid;
            victim_dirty = victim_dirty | way_sts[i].dirty;
         end
      end
   end

   assign hit_any  = |match_vec;
   assign used_way = hit_any ? hit_way : evict_way;

   // Broadcast the update; the state changes only when the transaction leaves stage 0.
   assign ctl.upd       = s0_move;
   assign ctl.hit_any   = hit_any;
   assign ctl.is_store  = s0_store_ff;
   assign ctl.used_rank = hit_any ? hit_rank : falwbt_pkg::OLDEST_RANK;

   // Stage 1: lookup result.
   logic          s1_hit_ff, s1_fetch_ff, s1_dev_ff, s1_cev_ff;
   logic [WB-1:0] s1_way_ff;
   logic [TB-1:0] s1_wb_tag_ff;
   logic          dev;

   assign dev = !hit_any && victim_valid && victim_dirty;

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_hit_ff    <= hit_any;
         s1_fetch_ff  <= !hit_any && !s0_store_ff;
         s1_dev_ff    <= dev;
         s1_cev_ff    <= !hit_any && victim_valid && !victim_dirty;
         s1_way_ff    <= used_way;
         // zero the tag unless a dirty line is written back, so the address reads 0
         s1_wb_tag_ff <= dev ? victim_tag : '0;
      end
   end

   // Stage 2: writeback address multiplier into the response register.
   logic [falwbt_pkg::PROD_BITS-1:0] wb_product;

   assign wb_product = falwbt_pkg::PROD_BITS'(s1_wb_tag_ff)
                     * falwbt_pkg::PROD_BITS'(gran_ff);

   always_ff @(posedge clock) begin
      if (s2_free) begin
         rsp_hit               <= s1_hit_ff;
         rsp_fetch_line        <= s1_fetch_ff;
         rsp_dirty_evict       <= s1_dev_ff;
         rsp_clean_evict       <= s1_cev_ff;
         rsp_writeback_address <= falwbt_pkg::WB_BITS'(wb_product);
         rsp_used_way          <= falwbt_pkg::USED_WAY_BITS'(s1_way_ff);
      end
   end

   assign rsp_valid = s2_valid_ff;

   // Assertions.
   `FALWBT_ASSERT_ALWAYS(a_one_oldest, clock, reset, $onehot(oldest_vec), "recency ranks lost their single oldest way")
   `FALWBT_ASSERT_ALWAYS(a_match_unique, clock, reset, $onehot0(match_vec), "tag present in more than one valid way")
   `FALWBT_ASSERT_IMPL(a_hit_no_evict, clock, reset, s1_valid_ff && s1_hit_ff, !s1_dev_ff && !s1_cev_ff && !s1_fetch_ff, "hit reported together with eviction or fetch")
   `FALWBT_ASSERT_NEXT(a_miss_moves, clock, reset, s0_move && !hit_any, s1_valid_ff && !s1_hit_ff && (s1_way_ff == $past(evict_way)), "miss did not fill the oldest way")

endmodule

### test/tb_fully_assoc_lru_writeback_tags.sv
// Self-checking testbench for fully_assoc_lru_writeback_tags: hits, misses, LRU victims,
// writeback addresses and the granularity register, with random request gaps and response stalls.
// Depends on falwbt_pkg and the fully_assoc_lru_writeback_tags RTL.
module tb_fully_assoc_lru_writeback_tags;

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 72;
   localparam int PHASE_ITEMS = 135;

   // One response transaction, packed in port order.
   typedef struct packed {
      logic                                 hit;
      logic                                 fetch_line;
      logic                                 dirty_evict;
      logic                                 clean_evict;
      logic [falwbt_pkg::WB_BITS-1:0]       wb_addr;
      logic [falwbt_pkg::USED_WAY_BITS-1:0] used_way;
   } lookup_rsp_type;

   // Shadow tag array with exact LRU list; predicts one response per request.
   class lookup_scoreboard;
      logic [falwbt_pkg::TAG_BITS-1:0]  tag_of   [falwbt_pkg::NUM_WAYS];
      bit                               valid_of [falwbt_pkg::NUM_WAYS];
      bit                               dirty_of [falwbt_pkg::NUM_WAYS];
      logic [falwbt_pkg::WAY_BITS-1:0]  older_of [falwbt_pkg::NUM_WAYS];
      logic [falwbt_pkg::WAY_BITS-1:0]  newer_of [falwbt_pkg::NUM_WAYS];
      logic [falwbt_pkg::WAY_BITS-1:0]  newest;
      logic [falwbt_pkg::WAY_BITS-1:0]  oldest;
      logic [falwbt_pkg::GRAN_BITS-1:0] gran;
      lookup_rsp_type                   expected_q[$];
      int errors, reported, hits, misses, dirty_victims, clean_victims;

      function new();
         for (int i = 0; i < falwbt_pkg::NUM_WAYS; i++) begin
            tag_of[i]   = '0;
            valid_of[i] = 1'b0;
            dirty_of[i] = 1'b0;
            older_of[i] = falwbt_pkg::WAY_BITS'(i + 1);
            newer_of[i] = falwbt_pkg::WAY_BITS'(i + falwbt_pkg::NUM_WAYS - 1);
         end
         newest = '0;
         oldest = falwbt_pkg::OLDEST_RANK;
         gran   = falwbt_pkg::GRAN_RESET;
      endfunction

      // Unlink way w and relink it at the newest end of the circular list.
      function void promote(logic [falwbt_pkg::WAY_BITS-1:0] w);
         logic [falwbt_pkg::WAY_BITS-1:0] nw, od, top, below_top;
         if (w == newest) return;
         nw = newer_of[w];
         od = older_of[w];
         older_of[nw] = od;
         newer_of[od] = nw;
         if (w == oldest) oldest = nw;
         top       = newest;
         below_top = newer_of[top];
         older_of[w]         = top;
         newer_of[w]         = below_top;
         newer_of[top]       = w;
         older_of[below_top] = w;
         newest = w;
      endfunction

      function void note_request(bit is_store, logic [falwbt_pkg::ADDR_BITS-1:0] addr);
         lookup_rsp_type                   r;
         logic [falwbt_pkg::TAG_BITS-1:0]  tag;
         logic [falwbt_pkg::WAY_BITS-1:0]  way;
         logic [falwbt_pkg::PROD_BITS-1:0] prod;
         bit                               found;
         r     = '0;
         tag   = addr[falwbt_pkg::TAG_BITS-1:0];
         found = 1'b0;
         way   = '0;
         for (int i = 0; i < falwbt_pkg::NUM_WAYS; i++) begin
            if (!found && valid_of[i] && tag_of[i] == tag) begin
               found = 1'b1;
               way   = falwbt_pkg::WAY_BITS'(i);
            end
         end
         if (found) begin
            r.hit = 1'b1;
            if (is_store) dirty_of[way] = 1'b1;
            hits++;
         end else begin
            way = oldest;
            if (valid_of[way]) begin
               if (dirty_of[way]) begin
                  r.dirty_evict = 1'b1;
                  prod = {{falwbt_pkg::GRAN_BITS{1'b0}}, tag_of[way]}
                       * {{falwbt_pkg::TAG_BITS{1'b0}}, gran};
                  r.wb_addr = prod[falwbt_pkg::WB_BITS-1:0];
                  dirty_victims++;
               end else begin
                  r.clean_evict = 1'b1;
                  clean_victims++;
               end
            end
            r.fetch_line  = !is_store;
            tag_of[way]   = tag;
            valid_of[way] = 1'b1;
            dirty_of[way] = is_store;
            misses++;
         end
         promote(way);
         r.used_way = falwbt_pkg::USED_WAY_BITS'(way);
         expected_q.push_back(r);
      endfunction

      function void check_response(lookup_rsp_type got);
         lookup_rsp_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: response with none pending: hit=%0b way=%0d", got.hit,
                        got.used_way);
            end
            return;
         end
         exp = expected_q.pop_front();
         if (got.hit !== exp.hit || got.fetch_line !== exp.fetch_line ||
             got.dirty_evict !== exp.dirty_evict || got.clean_evict !== exp.clean_evict ||
             got.wb_addr !== exp.wb_addr || got.used_way !== exp.used_way) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: expected hit=%0b fetch=%0b dirty=%0b clean=%0b wb=%h way=%0d",
                        exp.hit, exp.fetch_line, exp.dirty_evict, exp.clean_evict,
                        exp.wb_addr, exp.used_way);
               $display("       actual   hit=%0b fetch=%0b dirty=%0b clean=%0b wb=%h way=%0d",
                        got.hit, got.fetch_line, got.dirty_evict, got.clean_evict,
                        got.wb_addr, got.used_way);
            end
         end
      endfunction
   endclass

   logic                                 clock         = 1'b0;
   logic                                 reset         = 1'b1;
   logic                                 req_valid     = 1'b0;
   logic                                 req_stall;
   logic                                 req_func      = 1'b0;
   logic [falwbt_pkg::ADDR_BITS-1:0]     req_line_addr = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall     = 1'b0;
   logic                                 rsp_hit;
   logic                                 rsp_fetch_line;
   logic                                 rsp_dirty_evict;
   logic                                 rsp_clean_evict;
   logic [falwbt_pkg::WB_BITS-1:0]       rsp_writeback_address;
   logic [falwbt_pkg::USED_WAY_BITS-1:0] rsp_used_way;
   logic                                 csr_we        = 1'b0;
   logic [falwbt_pkg::GRAN_BITS-1:0]     csr_wdata     = '0;

   lookup_scoreboard                 sb;
   logic [falwbt_pkg::ADDR_BITS-1:0] addr_pool [POOL_SIZE];
   bit                               idle_on    = 1'b1;
   int                               stall_left = 0;
   int                               cycle_count = 0;
   int                               sent = 0;
   int                               gran_writes = 0;

   fully_assoc_lru_writeback_tags dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_line_addr         (req_line_addr),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_fetch_line        (rsp_fetch_line),
      .rsp_dirty_evict       (rsp_dirty_evict),
      .rsp_clean_evict       (rsp_clean_evict),
      .rsp_writeback_address (rsp_writeback_address),
      .rsp_used_way          (rsp_used_way),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata)
   );

   always #6 clock = ~clock;

   // Abort a hung run; the limit covers every gap and stall several times over.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d responses still pending", cycle_count,
                  sb.expected_q.size());
         $display("tb_fully_assoc_lru_writeback_tags: done, errors");
         $finish;
      end
   end

   // Response side: check each accepted transaction, then decide the stall for the next
   // cycle. Stall comes in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_hit, rsp_fetch_line, rsp_dirty_evict, rsp_clean_evict,
                            rsp_writeback_address, rsp_used_way});
      if (idle_on && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
   end

   function automatic logic [falwbt_pkg::ADDR_BITS-1:0] fresh_addr();
      return falwbt_pkg::ADDR_BITS'({$urandom(), $urandom()});
   endfunction

   // Present one request and hold it until accepted; note it in the scoreboard then.
   task automatic send_request(input bit is_store,
                               input logic [falwbt_pkg::ADDR_BITS-1:0] addr);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= is_store;
      req_line_addr <= addr;
      do @(posedge clock); while (req_stall);
      sb.note_request(is_store, addr);
      sent++;
   endtask

   // Drop valid and hold off until every pending response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Write the granularity register with the pipeline empty.
   task automatic write_granularity(input logic [falwbt_pkg::GRAN_BITS-1:0] value);
      drain();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.gran = value;
      gran_writes++;
   endtask

   // Mostly pool addresses (hits and LRU churn), some fresh full-width addresses, and
   // occasional streaks of 8 to 40 fresh misses that age much of the LRU list.
   task automatic run_random(input int count);
      int k, sel, streak;
      k = 0;
      while (k < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 2) begin
            streak = $urandom_range(8, 40);
            repeat (streak) send_request(1'($urandom_range(0, 1)), fresh_addr());
            k += streak;
         end else begin
            send_request(1'($urandom_range(0, 1)),
                         (sel < 82) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                    : fresh_addr());
            k++;
            if ($urandom_range(0, 199) == 0) drain();
         end
      end
   endtask

   initial begin
      logic [falwbt_pkg::GRAN_BITS-1:0] gran_plan [7];
      sb = new();
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = {1'b1, {(falwbt_pkg::ADDR_BITS-1){1'b0}}};
      for (int i = 3; i < POOL_SIZE; i++) addr_pool[i] = fresh_addr();
      gran_plan = '{falwbt_pkg::GRAN_BITS'(1), falwbt_pkg::GRAN_BITS'(4096),
                    falwbt_pkg::GRAN_BITS'(0), falwbt_pkg::GRAN_BITS'(8191),
                    falwbt_pkg::GRAN_BITS'($urandom_range(1, 4096)),
                    falwbt_pkg::GRAN_BITS'($urandom_range(1, 4096)),
                    falwbt_pkg::GRAN_RESET};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: first-use victim, hit, store hit marking dirty, store miss with no
      // fetch, and the address extremes, all at the reset granularity.
      send_request(1'b0, '0);
      send_request(1'b0, '0);
      send_request(1'b1, '0);
      send_request(1'b1, '1);
      send_request(1'b0, '1);
      send_request(1'b0, {1'b1, {(falwbt_pkg::ADDR_BITS-1){1'b0}}});
      send_request(1'b1, falwbt_pkg::ADDR_BITS'(1));
      send_request(1'b1, {(falwbt_pkg::ADDR_BITS/2){2'b01}});
      send_request(1'b0, {(falwbt_pkg::ADDR_BITS/2){2'b10}});
      send_request(1'b1, {1'b1, {(falwbt_pkg::ADDR_BITS-1){1'b0}}});
      send_request(1'b0, falwbt_pkg::ADDR_BITS'(1));
      send_request(1'b1, {(falwbt_pkg::ADDR_BITS/2){2'b10}});

      // Random phases, one per granularity setting; phase 2 and the last run without
      // idling on either side.
      for (int p = 0; p < 7; p++) begin
         idle_on = (p != 2 && p != 6);
         write_granularity(gran_plan[p]);
         run_random(PHASE_ITEMS);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d requests: %0d hits, %0d misses, %0d dirty and %0d clean victims",
               sent, sb.hits, sb.misses, sb.dirty_victims, sb.clean_victims);
      $display("granularity written %0d times incl. 0, 1, 4096 and 8191; %0d errors",
               gran_writes, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("tb_fully_assoc_lru_writeback_tags: done, clean");
      else
         $display("tb_fully_assoc_lru_writeback_tags: done, errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/falwbt_pkg.sv
rtl/falwbt_way.sv
rtl/fully_assoc_lru_writeback_tags.sv
test/tb_fully_assoc_lru_writeback_tags.sv
